[sv/sdsh_pkg.sv]
// Package for the SD card SPI-mode host sequencer.
// Holds field widths, operation codes, framing constants and register indexes.
`default_nettype none
package sdsh_pkg;
   localparam int SECTOR_BYTES = 512;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [2:0] {
      MODE_INIT = 3'd0, MODE_READ = 3'd1, MODE_OPEN = 3'd2,
      MODE_WBYTE = 3'd3, MODE_FINISH = 3'd4, MODE_CARD = 3'd5
   } mode_type;

   localparam logic [2:0] CSR_TOKEN_TIMEOUT = 3'd0;
   localparam logic [2:0] CSR_BUSY_TIMEOUT  = 3'd1;
   localparam logic [2:0] CSR_RESPONSE_POLLS = 3'd2;
   localparam logic [2:0] CSR_INIT_RETRIES  = 3'd3;
   localparam logic [2:0] CSR_WAKEUP_BYTES  = 3'd4;

   localparam logic [7:0] CRC_CMD0 = 8'h95;
   localparam logic [7:0] CRC_CMD8 = 8'h87;
   localparam logic [31:0] ARG_CMD8 = 32'h0000_01AA;
   localparam logic [31:0] ARG_ACMD41 = 32'h4000_0000;
   localparam logic [31:0] ARG_CMD16 = 32'h0000_0200;
   localparam logic [7:0] TOKEN_START = 8'hFE;
   localparam logic [7:0] DRESP_MASK = 8'h1F;
   localparam logic [7:0] DRESP_OK = 8'h05;

   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] sector;
      logic [8:0]  offset;
      logic [9:0]  count;
      logic [7:0]  write_byte;
      logic [7:0]  card_byte;
      logic        discard;
   } req_type;

   typedef struct packed {
      logic       mosi_valid;
      logic [7:0] mosi_byte;
      logic       selected;
      logic       data_valid;
      logic [7:0] data_byte;
      logic       done_res;
      logic       status;
   } rsp_type;
endpackage
`default_nettype wire

[sv/sdsh_if.sv]
// Valid/ready channel interface for the sequencer.
// Depends on nothing; payload type is a parameter.
`default_nettype none
interface sdsh_if #(parameter type payload_type = logic) (input wire logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[sv/sd_spi_host_sequencer_unit.sv]
// SD SPI-mode host sequencer: one request transaction in, one response transaction out.
// Depends on sdsh_pkg and sdsh_if.
//
// Each request (an operation start or the MISO byte of the last exchange) yields one
// response in the cycle after acceptance. A new request is accepted every cycle while
// the response register is empty or being drained; throughput is one transaction per
// clock, set by the single registered decision step over the sequencer state.
`default_nettype none
module sd_spi_host_sequencer_unit (
   input wire logic clock,
   input wire logic reset,
   sdsh_if.sink     req,
   sdsh_if.source   rsp,
   input wire logic csr_we,
   input wire logic [sdsh_pkg::CSR_IDX_W-1:0] csr_index,
   input wire logic [sdsh_pkg::CSR_DATA_W-1:0] csr_data
);
   typedef enum logic [4:0] {
      ST_IDLE, ST_WAKE, ST_CMD0, ST_CMD8, ST_CMD58A, ST_CMD55, ST_ACMD41, ST_CMD58B,
      ST_CMD16, ST_CMD17, ST_CMD24, ST_CMD13, ST_R7, ST_OCRA, ST_OCRB, ST_TOKEN,
      ST_RDATA, ST_RTAIL_OK, ST_RTAIL_ERR, ST_WHDR, ST_WBYTE, ST_WPAD, ST_WRESP,
      ST_BUSY, ST_STAT
   } phase_type;

   phase_type phase_ff, phase_in;
   logic [47:0] frame_ff, frame_in;
   logic [9:0]  bcnt_ff, bcnt_in;
   logic [15:0] wcnt_ff, wcnt_in;
   logic [7:0]  retry_ff, retry_in;
   logic [31:0] cap_ff, cap_in;
   logic        blk_ff, blk_in;
   logic [9:0]  wrem_ff, wrem_in;
   logic [15:0] tok_to_ff, busy_to_ff;
   logic [7:0]  polls_ff, retries_ff, wake_ff;
   sdsh_pkg::rsp_type res_ff, res_in;
   logic        full_ff;
   sdsh_pkg::req_type q;

   logic [15:0] tok_lim, busy_lim;
   logic [7:0]  poll_lim, retry_lim;
   logic        accept;

   assign q = req.payload;
   assign req.ready = !full_ff || rsp.ready;
   assign accept = req.valid && req.ready;
   assign rsp.valid = full_ff;
   assign rsp.payload = res_ff;
   assign tok_lim = (tok_to_ff == '0) ? 16'd1 : tok_to_ff;
   assign busy_lim = (busy_to_ff == '0) ? 16'd1 : busy_to_ff;
   assign poll_lim = (polls_ff == '0) ? 8'd1 : polls_ff;
   assign retry_lim = (retries_ff == '0) ? 8'd1 : retries_ff;

   function automatic logic [47:0] mk_frame(input logic [5:0] cmd, input logic [31:0] arg);
      logic [7:0] crc;
      crc = (cmd == 6'd0) ? sdsh_pkg::CRC_CMD0 :
            (cmd == 6'd8) ? sdsh_pkg::CRC_CMD8 : 8'h01;
      return {2'b01, cmd, arg, crc};
   endfunction

   // Next state and response for one request
   always_comb begin
      logic [9:0] cnt, room, nb;
      logic [15:0] w1;
      logic [31:0] addr, cap_sh;
      logic [7:0] cb, r1;
      logic [47:0] fr;
      logic [5:0] cmd;
      logic [31:0] arg;
      logic       do_issue;
      phase_type  iss_ph;
      phase_in = phase_ff; frame_in = frame_ff; bcnt_in = bcnt_ff; wcnt_in = wcnt_ff;
      retry_in = retry_ff; cap_in = cap_ff; blk_in = blk_ff; wrem_in = wrem_ff;
      res_in = '0;
      do_issue = 1'b0; iss_ph = ST_IDLE; cmd = '0; arg = '0;
      fr = '0;
      cb = q.card_byte;
      r1 = cb;
      w1 = wcnt_ff + 16'd1;
      cnt = q.count; room = 10'(sdsh_pkg::SECTOR_BYTES) - {1'b0, q.offset};
      nb = bcnt_ff + 10'd1;
      addr = blk_ff ? q.sector : {q.sector[22:0], 9'd0};
      cap_sh = {cap_ff[23:0], cb};
      case (q.mode)
         sdsh_pkg::MODE_INIT: begin
            blk_in = 1'b0; wrem_in = '0; retry_in = '0;
            if (wake_ff == '0) begin
               do_issue = 1'b1; iss_ph = ST_CMD0; cmd = 6'd0; arg = '0;
            end else begin
               phase_in = ST_WAKE; wcnt_in = '0;
               res_in.mosi_valid = 1'b1; res_in.mosi_byte = 8'hFF;
            end
         end
         sdsh_pkg::MODE_READ: begin
            if (cnt > room) cnt = room;
            cap_in = {11'd0, q.discard, {1'b0, q.offset} + cnt, 1'b0, q.offset};
            do_issue = 1'b1; iss_ph = ST_CMD17; cmd = 6'd17; arg = addr;
         end
         sdsh_pkg::MODE_OPEN: begin
            do_issue = 1'b1; iss_ph = ST_CMD24; cmd = 6'd24; arg = addr;
         end
         sdsh_pkg::MODE_WBYTE: begin
            if (wrem_ff != '0) begin
               wrem_in = wrem_ff - 10'd1; phase_in = ST_WBYTE;
               res_in.mosi_valid = 1'b1; res_in.mosi_byte = q.write_byte;
               res_in.selected = 1'b1;
            end else begin
               phase_in = ST_IDLE; res_in.done_res = 1'b1;
            end
         end
         sdsh_pkg::MODE_FINISH: begin
            wcnt_in = {6'd0, wrem_ff} + 16'd1; wrem_in = '0; phase_in = ST_WPAD;
            res_in.mosi_valid = 1'b1; res_in.mosi_byte = 8'h00; res_in.selected = 1'b1;
         end
         sdsh_pkg::MODE_CARD: begin
            case (phase_ff)
               ST_CMD0, ST_CMD8, ST_CMD58A, ST_CMD55, ST_ACMD41, ST_CMD58B,
               ST_CMD16, ST_CMD17, ST_CMD24, ST_CMD13: begin
                  if (bcnt_ff < 10'd5) begin
                     bcnt_in = nb; fr = frame_ff << {nb[2:0], 3'd0};
                     res_in.mosi_valid = 1'b1; res_in.mosi_byte = fr[47:40];
                     res_in.selected = 1'b1;
                  end else if (bcnt_ff == 10'd5) begin
                     bcnt_in = 10'd6; wcnt_in = '0;
                     res_in.mosi_valid = 1'b1; res_in.mosi_byte = 8'hFF;
                     res_in.selected = 1'b1;
                  end else begin
                     wcnt_in = w1;
                     if (cb[7] && w1 < {8'd0, poll_lim}) begin
                        res_in.mosi_valid = 1'b1; res_in.mosi_byte = 8'hFF;
                        res_in.selected = 1'b1;
                     end else begin
                        // Act on the R1 response
                        case (phase_ff)
                           ST_CMD0:
                              if (r1 == 8'd1) begin
                                 do_issue = 1'b1; iss_ph = ST_CMD8; cmd = 6'd8;
                                 arg = sdsh_pkg::ARG_CMD8;
                              end else begin
                                 phase_in = ST_IDLE; res_in.done_res = 1'b1;
                                 res_in.status = 1'b1;
                              end
                           ST_CMD8, ST_CMD58A:
                              if (r1 == 8'd1) begin
                                 phase_in = (phase_ff == ST_CMD8) ? ST_R7 : ST_OCRA;
                                 bcnt_in = '0; cap_in = '0;
                                 res_in.mosi_valid = 1'b1; res_in.mosi_byte = 8'hFF;
                                 res_in.selected = 1'b1;
                              end else begin
                                 phase_in = ST_IDLE; res_in.done_res = 1'b1;
                                 res_in.status = (phase_ff == ST_CMD58A);
                              end
                           ST_CMD55: begin
                              do_issue = 1'b1; iss_ph = ST_ACMD41; cmd = 6'd41;
                              arg = sdsh_pkg::ARG_ACMD41;
                           end
                           ST_ACMD41:
                              if (r1 == 8'd0) begin
                                 do_issue = 1'b1; iss_ph = ST_CMD58B; cmd = 6'd58;
                              end else begin
                                 retry_in = retry_ff + 8'd1;
                                 if (retry_in >= retry_lim) begin
                                    phase_in = ST_IDLE; res_in.done_res = 1'b1;
                                    res_in.status = 1'b1;
                                 end else begin
                                    do_issue = 1'b1; iss_ph = ST_CMD55; cmd = 6'd55;
                                 end
                              end
                           ST_CMD58B:
                              if (r1 == 8'd0) begin
                                 phase_in = ST_OCRB; bcnt_in = '0; cap_in = '0;
                                 res_in.mosi_valid = 1'b1; res_in.mosi_byte = 8'hFF;
                                 res_in.selected = 1'b1;
                              end else begin
                                 phase_in = ST_IDLE; res_in.done_res = 1'b1;
                                 res_in.status = 1'b1;
                              end
                           ST_CMD16: begin
                              if (r1 == 8'd0) blk_in = 1'b0;
                              phase_in = ST_IDLE; res_in.done_res = 1'b1;
                              res_in.status = (r1 != 8'd0);
                           end
                           ST_CMD17:
                              if (r1 == 8'd0) begin
                                 phase_in = ST_TOKEN; wcnt_in = '0;
                                 res_in.mosi_valid = 1'b1; res_in.mosi_byte = 8'hFF;
                                 res_in.selected = 1'b1;
                              end else begin
                                 phase_in = ST_IDLE; res_in.done_res = 1'b1;
                                 res_in.status = 1'b1;
                              end
                           ST_CMD24:
                              if (r1 == 8'd0) begin
                                 phase_in = ST_WHDR; bcnt_in = '0;
                                 res_in.mosi_valid = 1'b1; res_in.mosi_byte = 8'hFF;
                                 res_in.selected = 1'b1;
                              end else begin
                                 wrem_in = '0; phase_in = ST_IDLE;
                                 res_in.done_res = 1'b1; res_in.status = 1'b1;
                              end
                           default: begin
                              phase_in = ST_STAT;
                              res_in.mosi_valid = 1'b1; res_in.mosi_byte = 8'hFF;
                              res_in.selected = 1'b1;
                           end
                        endcase
                     end
                  end
               end
               ST_WAKE: begin
                  wcnt_in = w1;
                  if (w1 >= {8'd0, wake_ff}) begin
                     do_issue = 1'b1; iss_ph = ST_CMD0; cmd = 6'd0;
                  end else begin
                     res_in.mosi_valid = 1'b1; res_in.mosi_byte = 8'hFF;
                  end
               end
               ST_R7, ST_OCRA, ST_OCRB: begin
                  cap_in = cap_sh; bcnt_in = nb;
                  if (nb < 10'd4) begin
                     res_in.mosi_valid = 1'b1; res_in.mosi_byte = 8'hFF;
                     res_in.selected = 1'b1;
                  end else if (phase_ff == ST_R7) begin
                     if (cap_sh[15:8] == 8'h01 && cap_sh[7:0] == 8'hAA) begin
                        do_issue = 1'b1; iss_ph = ST_CMD58A; cmd = 6'd58;
                     end else begin
                        phase_in = ST_IDLE; res_in.done_res = 1'b1; res_in.status = 1'b1;
                     end
                  end else if (phase_ff == ST_OCRA) begin
                     if ((cap_sh[23:16] & 8'h30) != '0) begin
                        retry_in = '0; do_issue = 1'b1; iss_ph = ST_CMD55; cmd = 6'd55;
                     end else begin
                        phase_in = ST_IDLE; res_in.done_res = 1'b1; res_in.status = 1'b1;
                     end
                  end else if (cap_sh[30]) begin
                     blk_in = 1'b1; phase_in = ST_IDLE; res_in.done_res = 1'b1;
                  end else begin
                     do_issue = 1'b1; iss_ph = ST_CMD16; cmd = 6'd16;
                     arg = sdsh_pkg::ARG_CMD16;
                  end
               end
               ST_TOKEN: begin
                  if (cb == sdsh_pkg::TOKEN_START) begin
                     phase_in = ST_RDATA; bcnt_in = '0;
                     res_in.mosi_valid = 1'b1; res_in.mosi_byte = 8'hFF;
                     res_in.selected = 1'b1;
                  end else begin
                     wcnt_in = w1;
                     res_in.mosi_valid = 1'b1; res_in.mosi_byte = 8'hFF;
                     if (w1 >= tok_lim) phase_in = ST_RTAIL_ERR;
                     else res_in.selected = 1'b1;
                  end
               end
               ST_RDATA: begin
                  if (bcnt_ff >= cap_ff[9:0] && bcnt_ff < cap_ff[19:10] && !cap_ff[20]) begin
                     res_in.data_valid = 1'b1; res_in.data_byte = cb;
                  end
                  bcnt_in = nb;
                  res_in.mosi_valid = 1'b1; res_in.mosi_byte = 8'hFF;
                  if (nb < 10'(sdsh_pkg::SECTOR_BYTES + 2)) res_in.selected = 1'b1;
                  else phase_in = ST_RTAIL_OK;
               end
               ST_RTAIL_OK, ST_RTAIL_ERR, ST_WBYTE: begin
                  res_in.done_res = 1'b1; res_in.status = (phase_ff == ST_RTAIL_ERR);
                  phase_in = ST_IDLE;
               end
               ST_WHDR: begin
                  if (bcnt_ff == '0) begin
                     bcnt_in = 10'd1;
                     res_in.mosi_valid = 1'b1; res_in.mosi_byte = sdsh_pkg::TOKEN_START;
                     res_in.selected = 1'b1;
                  end else begin
                     wrem_in = 10'(sdsh_pkg::SECTOR_BYTES);
                     phase_in = ST_IDLE; res_in.done_res = 1'b1;
                  end
               end
               ST_WPAD: begin
                  res_in.mosi_valid = 1'b1; res_in.selected = 1'b1;
                  if (wcnt_ff != '0) begin
                     wcnt_in = wcnt_ff - 16'd1; res_in.mosi_byte = 8'h00;
                  end else begin
                     phase_in = ST_WRESP; res_in.mosi_byte = 8'hFF;
                  end
               end
               ST_WRESP: begin
                  if ((cb & sdsh_pkg::DRESP_MASK) == sdsh_pkg::DRESP_OK) begin
                     phase_in = ST_BUSY; wcnt_in = '0;
                     res_in.mosi_valid = 1'b1; res_in.mosi_byte = 8'hFF;
                     res_in.selected = 1'b1;
                  end else begin
                     phase_in = ST_IDLE; res_in.done_res = 1'b1; res_in.status = 1'b1;
                  end
               end
               ST_BUSY: begin
                  if (cb == 8'hFF) begin
                     do_issue = 1'b1; iss_ph = ST_CMD13; cmd = 6'd13;
                  end else begin
                     wcnt_in = w1;
                     if (w1 >= busy_lim) begin
                        phase_in = ST_IDLE; res_in.done_res = 1'b1; res_in.status = 1'b1;
                     end else begin
                        res_in.mosi_valid = 1'b1; res_in.mosi_byte = 8'hFF;
                        res_in.selected = 1'b1;
                     end
                  end
               end
               ST_STAT: begin
                  phase_in = ST_IDLE; res_in.done_res = 1'b1; res_in.status = (cb != 8'd0);
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      // Launch a command frame
      if (do_issue) begin
         fr = mk_frame(cmd, arg);
         phase_in = iss_ph; frame_in = fr; bcnt_in = '0; wcnt_in = '0;
         res_in.mosi_valid = 1'b1; res_in.mosi_byte = fr[47:40]; res_in.selected = 1'b1;
      end
   end

   // Hold state, configuration and the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ST_IDLE; frame_ff <= '0; bcnt_ff <= '0; wcnt_ff <= '0;
         retry_ff <= '0; cap_ff <= '0; blk_ff <= 1'b0; wrem_ff <= '0;
         tok_to_ff <= 16'd4000; busy_to_ff <= 16'd5000; polls_ff <= 8'd10;
         retries_ff <= 8'd10; wake_ff <= 8'd11; full_ff <= 1'b0;
         res_ff <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               sdsh_pkg::CSR_TOKEN_TIMEOUT: tok_to_ff <= csr_data;
               sdsh_pkg::CSR_BUSY_TIMEOUT: busy_to_ff <= csr_data;
               sdsh_pkg::CSR_RESPONSE_POLLS: polls_ff <= csr_data[7:0];
               sdsh_pkg::CSR_INIT_RETRIES: retries_ff <= csr_data[7:0];
               sdsh_pkg::CSR_WAKEUP_BYTES: wake_ff <= csr_data[7:0];
               default: ;
            endcase
         end
         if (accept) begin
            phase_ff <= phase_in; frame_ff <= frame_in; bcnt_ff <= bcnt_in;
            wcnt_ff <= wcnt_in; retry_ff <= retry_in; cap_ff <= cap_in;
            blk_ff <= blk_in; wrem_ff <= wrem_in;
            res_ff <= res_in;
            full_ff <= 1'b1;
         end else if (rsp.ready) begin
            full_ff <= 1'b0;
         end
      end
   end
endmodule
`default_nettype wire

[sv/sdsh_checker.sv]
// Port-level checker for the SD SPI host sequencer, with its bind.
// Depends on sdsh_pkg and sdsh_if.
`default_nettype none
module sdsh_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire sdsh_pkg::rsp_type rsp_payload
);
   // Accepted request yields a response next cycle
   a_resp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid) else $error("no response");
   // Stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_payload)) else $error("payload moved");
   // Idle exchange fields are zero
   a_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.mosi_valid |-> !rsp_payload.selected
      && rsp_payload.mosi_byte == 8'h00) else $error("quiet fields set");
   // Status only with done
   a_stat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status |-> rsp_payload.done_res) else $error("stray status");
endmodule

bind sd_spi_host_sequencer_unit sdsh_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload)
);
`default_nettype wire

[tb/tb_sd_spi_host_sequencer_unit.sv]
// Self-checking testbench for the SD card SPI-mode host sequencer.
// Depends on sdsh_pkg, sdsh_if and sd_spi_host_sequencer_unit; a scripted card answers
// every exchange and a state-level predictor checks each response transaction in order.
`default_nettype none
module tb_sd_spi_host_sequencer_unit;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [5:0] {
      PH_IDLE, PH_WAKE, PH_CMD0, PH_CMD8, PH_CMD58A, PH_CMD55, PH_ACMD41, PH_CMD58B,
      PH_CMD16, PH_CMD17, PH_CMD24, PH_CMD13, PH_R7, PH_OCRA, PH_OCRB, PH_TOKEN,
      PH_RDATA, PH_RTAIL_OK, PH_RTAIL_ERR, PH_WHDR, PH_WBYTE, PH_WPAD, PH_WRESP,
      PH_BUSY, PH_STAT
   } seq_phase_type;

   localparam logic [5:0] CMD_GO_IDLE = 6'd0;
   localparam logic [5:0] CMD_IF_COND = 6'd8;
   localparam logic [5:0] CMD_SEND_STATUS = 6'd13;
   localparam logic [5:0] CMD_SET_BLOCKLEN = 6'd16;
   localparam logic [5:0] CMD_READ_BLOCK = 6'd17;
   localparam logic [5:0] CMD_WRITE_BLOCK = 6'd24;
   localparam logic [5:0] CMD_SD_SEND_OP = 6'd41;
   localparam logic [5:0] CMD_APP = 6'd55;
   localparam logic [5:0] CMD_READ_OCR = 6'd58;
   localparam logic [2:0] MODE_RSVD6 = 3'd6;
   localparam logic [2:0] MODE_RSVD7 = 3'd7;

   typedef struct {
      seq_phase_type ph;
      logic [47:0] frame;
      logic [9:0]  bcnt;
      logic [15:0] wcnt;
      logic [7:0]  retries_used;
      logic [31:0] capture;
      logic        blk_addr;
      logic [9:0]  wr_left;
      logic [15:0] token_to;
      logic [15:0] busy_to;
      logic [7:0]  polls;
      logic [7:0]  retries;
      logic [7:0]  wake;
   } host_state_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [sdsh_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [sdsh_pkg::CSR_DATA_W-1:0] csr_data = '0;

   sdsh_if #(.payload_type(sdsh_pkg::req_type)) req_if (clock);
   sdsh_if #(.payload_type(sdsh_pkg::rsp_type)) rsp_if (clock);

   sd_spi_host_sequencer_unit dut (
      .clock(clock), .reset(reset), .req(req_if), .rsp(rsp_if),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   host_state_type    chk_state;   // follows accepted transactions
   host_state_type    plan_state;  // follows generated transactions
   sdsh_pkg::req_type cmd_queue[$];
   sdsh_pkg::rsp_type rsp_expected[$];
   int          n_accepted = 0;
   int          n_queued = 0;
   int          n_errors = 0;
   logic        req_fire = 1'b0;

   always #10 clock = ~clock;

   // ---------------- predictor ----------------
   function automatic void put_byte(inout sdsh_pkg::rsp_type o, input logic [7:0] b,
                                    input logic sel);
      o.mosi_valid = 1'b1;
      o.mosi_byte = b;
      o.selected = sel;
   endfunction

   function automatic void end_op(inout host_state_type s, inout sdsh_pkg::rsp_type o,
                                  input logic st);
      s.ph = PH_IDLE;
      o.done_res = 1'b1;
      o.status = st;
   endfunction

   function automatic void launch_cmd(inout host_state_type s, inout sdsh_pkg::rsp_type o,
                                      input seq_phase_type ph, input logic [5:0] cmd,
                                      input logic [31:0] arg);
      logic [7:0] crc;
      crc = (cmd == CMD_GO_IDLE) ? sdsh_pkg::CRC_CMD0 :
            (cmd == CMD_IF_COND) ? sdsh_pkg::CRC_CMD8 : 8'h01;
      s.ph = ph;
      s.frame = {2'b01, cmd, arg, crc};
      s.bcnt = '0;
      s.wcnt = '0;
      put_byte(o, s.frame[47:40], 1'b1);
   endfunction

   function automatic void start_reply(inout host_state_type s, inout sdsh_pkg::rsp_type o,
                                       input seq_phase_type ph);
      s.ph = ph;
      s.bcnt = '0;
      s.capture = '0;
      put_byte(o, 8'hFF, 1'b1);
   endfunction

   function automatic logic [31:0] card_addr(input host_state_type s,
                                             input logic [31:0] sector);
      return s.blk_addr ? sector : sector * 32'(sdsh_pkg::SECTOR_BYTES);
   endfunction

   // Handle the R1 that ends a command's poll window.
   function automatic void take_r1(inout host_state_type s, inout sdsh_pkg::rsp_type o,
                                   input logic [7:0] r);
      case (s.ph)
         PH_CMD0: if (r == 8'd1) launch_cmd(s, o, PH_CMD8, CMD_IF_COND, sdsh_pkg::ARG_CMD8);
                  else end_op(s, o, 1'b1);
         PH_CMD8: if (r == 8'd1) start_reply(s, o, PH_R7);
                  else end_op(s, o, 1'b0);
         PH_CMD58A: if (r == 8'd1) start_reply(s, o, PH_OCRA);
                    else end_op(s, o, 1'b1);
         PH_CMD55: launch_cmd(s, o, PH_ACMD41, CMD_SD_SEND_OP, sdsh_pkg::ARG_ACMD41);
         PH_ACMD41: begin
            if (r == 8'd0) launch_cmd(s, o, PH_CMD58B, CMD_READ_OCR, 32'd0);
            else begin
               s.retries_used = s.retries_used + 8'd1;
               if (s.retries_used >= ((s.retries == 0) ? 8'd1 : s.retries)) end_op(s, o, 1'b1);
               else launch_cmd(s, o, PH_CMD55, CMD_APP, 32'd0);
            end
         end
         PH_CMD58B: if (r == 8'd0) start_reply(s, o, PH_OCRB);
                    else end_op(s, o, 1'b1);
         PH_CMD16: begin
            if (r == 8'd0) begin
               s.blk_addr = 1'b0;
               end_op(s, o, 1'b0);
            end else end_op(s, o, 1'b1);
         end
         PH_CMD17: begin
            if (r == 8'd0) begin
               s.ph = PH_TOKEN;
               s.wcnt = '0;
               put_byte(o, 8'hFF, 1'b1);
            end else end_op(s, o, 1'b1);
         end
         PH_CMD24: begin
            if (r == 8'd0) begin
               s.ph = PH_WHDR;
               s.bcnt = '0;
               put_byte(o, 8'hFF, 1'b1);
            end else begin
               s.wr_left = '0;
               end_op(s, o, 1'b1);
            end
         end
         default: begin
            s.ph = PH_STAT;
            put_byte(o, 8'hFF, 1'b1);
         end
      endcase
   endfunction

   // Four-byte R7 / OCR payloads.
   function automatic void take_word(inout host_state_type s, inout sdsh_pkg::rsp_type o);
      if (s.ph == PH_R7) begin
         if (s.capture[15:8] == 8'h01 && s.capture[7:0] == 8'hAA)
            launch_cmd(s, o, PH_CMD58A, CMD_READ_OCR, 32'd0);
         else end_op(s, o, 1'b1);
      end else if (s.ph == PH_OCRA) begin
         if ((s.capture[23:16] & 8'h30) != 8'd0) begin
            s.retries_used = '0;
            launch_cmd(s, o, PH_CMD55, CMD_APP, 32'd0);
         end else end_op(s, o, 1'b1);
      end else begin
         if (s.capture[30]) begin
            s.blk_addr = 1'b1;
            end_op(s, o, 1'b0);
         end else launch_cmd(s, o, PH_CMD16, CMD_SET_BLOCKLEN, sdsh_pkg::ARG_CMD16);
      end
   endfunction

   function automatic void take_card(inout host_state_type s, inout sdsh_pkg::rsp_type o,
                                     input logic [7:0] cb);
      if (s.ph >= PH_CMD0 && s.ph <= PH_CMD13) begin
         if (s.bcnt < 10'd5) begin
            s.bcnt = s.bcnt + 10'd1;
            put_byte(o, s.frame[47 - 8 * s.bcnt -: 8], 1'b1);
         end else if (s.bcnt == 10'd5) begin
            s.bcnt = 10'd6;
            s.wcnt = '0;
            put_byte(o, 8'hFF, 1'b1);
         end else begin
            s.wcnt = s.wcnt + 16'd1;
            if (cb[7] && s.wcnt < {8'd0, (s.polls == 0) ? 8'd1 : s.polls})
               put_byte(o, 8'hFF, 1'b1);
            else take_r1(s, o, cb);
         end
         return;
      end
      case (s.ph)
         PH_WAKE: begin
            s.wcnt = s.wcnt + 16'd1;
            if (s.wcnt >= {8'd0, s.wake}) launch_cmd(s, o, PH_CMD0, CMD_GO_IDLE, 32'd0);
            else put_byte(o, 8'hFF, 1'b0);
         end
         PH_R7, PH_OCRA, PH_OCRB: begin
            s.capture = {s.capture[23:0], cb};
            s.bcnt = s.bcnt + 10'd1;
            if (s.bcnt < 10'd4) put_byte(o, 8'hFF, 1'b1);
            else take_word(s, o);
         end
         PH_TOKEN: begin
            if (cb == sdsh_pkg::TOKEN_START) begin
               s.ph = PH_RDATA;
               s.bcnt = '0;
               put_byte(o, 8'hFF, 1'b1);
            end else begin
               s.wcnt = s.wcnt + 16'd1;
               if (s.wcnt >= ((s.token_to == 0) ? 16'd1 : s.token_to)) begin
                  s.ph = PH_RTAIL_ERR;
                  put_byte(o, 8'hFF, 1'b0);
               end else put_byte(o, 8'hFF, 1'b1);
            end
         end
         PH_RDATA: begin
            if (s.bcnt >= s.capture[9:0] && s.bcnt < s.capture[19:10] && !s.capture[20]) begin
               o.data_valid = 1'b1;
               o.data_byte = cb;
            end
            s.bcnt = s.bcnt + 10'd1;
            if (s.bcnt < sdsh_pkg::SECTOR_BYTES + 2) put_byte(o, 8'hFF, 1'b1);
            else begin
               s.ph = PH_RTAIL_OK;
               put_byte(o, 8'hFF, 1'b0);
            end
         end
         PH_RTAIL_OK: end_op(s, o, 1'b0);
         PH_RTAIL_ERR: end_op(s, o, 1'b1);
         PH_WHDR: begin
            if (s.bcnt == 10'd0) begin
               s.bcnt = 10'd1;
               put_byte(o, sdsh_pkg::TOKEN_START, 1'b1);
            end else begin
               s.wr_left = 10'(sdsh_pkg::SECTOR_BYTES);
               end_op(s, o, 1'b0);
            end
         end
         PH_WBYTE: end_op(s, o, 1'b0);
         PH_WPAD: begin
            if (s.wcnt > 16'd0) begin
               s.wcnt = s.wcnt - 16'd1;
               put_byte(o, 8'h00, 1'b1);
            end else begin
               s.ph = PH_WRESP;
               put_byte(o, 8'hFF, 1'b1);
            end
         end
         PH_WRESP: begin
            if ((cb & sdsh_pkg::DRESP_MASK) == sdsh_pkg::DRESP_OK) begin
               s.ph = PH_BUSY;
               s.wcnt = '0;
               put_byte(o, 8'hFF, 1'b1);
            end else end_op(s, o, 1'b1);
         end
         PH_BUSY: begin
            if (cb == 8'hFF) launch_cmd(s, o, PH_CMD13, CMD_SEND_STATUS, 32'd0);
            else begin
               s.wcnt = s.wcnt + 16'd1;
               if (s.wcnt >= ((s.busy_to == 0) ? 16'd1 : s.busy_to)) end_op(s, o, 1'b1);
               else put_byte(o, 8'hFF, 1'b1);
            end
         end
         PH_STAT: end_op(s, o, cb != 8'd0);
         default: ;
      endcase
   endfunction

   function automatic void host_step(inout host_state_type s, input sdsh_pkg::req_type r,
                                     output sdsh_pkg::rsp_type o);
      logic [9:0] len;
      o = '0;
      case (r.mode)
         sdsh_pkg::MODE_INIT: begin
            s.blk_addr = 1'b0;
            s.wr_left = '0;
            s.retries_used = '0;
            if (s.wake == 0) launch_cmd(s, o, PH_CMD0, CMD_GO_IDLE, 32'd0);
            else begin
               s.ph = PH_WAKE;
               s.wcnt = '0;
               put_byte(o, 8'hFF, 1'b0);
            end
         end
         sdsh_pkg::MODE_READ: begin
            len = r.count;
            if (len > 10'd512 - {1'b0, r.offset}) len = 10'd512 - {1'b0, r.offset};
            s.capture = {11'd0, r.discard, {1'b0, r.offset} + len, {1'b0, r.offset}};
            launch_cmd(s, o, PH_CMD17, CMD_READ_BLOCK, card_addr(s, r.sector));
         end
         sdsh_pkg::MODE_OPEN:
            launch_cmd(s, o, PH_CMD24, CMD_WRITE_BLOCK, card_addr(s, r.sector));
         sdsh_pkg::MODE_WBYTE: begin
            if (s.wr_left > 0) begin
               s.wr_left = s.wr_left - 10'd1;
               s.ph = PH_WBYTE;
               put_byte(o, r.write_byte, 1'b1);
            end else end_op(s, o, 1'b0);
         end
         sdsh_pkg::MODE_FINISH: begin
            s.wcnt = {6'd0, s.wr_left} + 16'd1;
            s.wr_left = '0;
            s.ph = PH_WPAD;
            put_byte(o, 8'h00, 1'b1);
         end
         sdsh_pkg::MODE_CARD: take_card(s, o, r.card_byte);
         default: ;
      endcase
   endfunction

   function automatic void state_reset(inout host_state_type s);
      s.ph = PH_IDLE;
      s.frame = '0;
      s.bcnt = '0;
      s.wcnt = '0;
      s.retries_used = '0;
      s.capture = '0;
      s.blk_addr = 1'b0;
      s.wr_left = '0;
      s.token_to = 16'd4000;
      s.busy_to = 16'd5000;
      s.polls = 8'd10;
      s.retries = 8'd10;
      s.wake = 8'd11;
   endfunction

   // ---------------- driver ----------------
   always @(negedge clock) begin
      int send_idle, recv_idle;
      send_idle = (n_accepted < 520) ? 7 : (n_accepted < 1040) ? 87 : 0;
      recv_idle = (n_accepted < 520) ? 87 : (n_accepted < 1040) ? 7 : 0;
      if (reset) begin
         req_if.valid <= 1'b0;
         rsp_if.ready <= 1'b0;
      end else begin
         // advance to the next transaction once the current one is taken
         if (!req_if.valid || req_fire) begin
            if (cmd_queue.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
               req_if.payload <= cmd_queue.pop_front();
               req_if.valid <= 1'b1;
            end else req_if.valid <= 1'b0;
         end
         rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle);
      end
   end

   // ---------------- monitor and checker ----------------
   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         n_errors++;
      end
   endtask

   always @(posedge clock) begin
      sdsh_pkg::rsp_type want, got;
      req_fire <= !reset && req_if.valid && req_if.ready;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.payload;
            if (rsp_expected.size() == 0) begin
               $error("unexpected response transaction %0h", got);
               n_errors++;
            end else begin
               want = rsp_expected.pop_front();
               check_field("mosi_valid", want.mosi_valid, got.mosi_valid);
               check_field("mosi_byte", want.mosi_byte, got.mosi_byte);
               check_field("selected", want.selected, got.selected);
               check_field("data_valid", want.data_valid, got.data_valid);
               check_field("data_byte", want.data_byte, got.data_byte);
               check_field("done_res", want.done_res, got.done_res);
               check_field("status", want.status, got.status);
            end
         end
         if (req_if.valid && req_if.ready) begin
            host_step(chk_state, req_if.payload, want);
            rsp_expected.push_back(want);
            n_accepted++;
         end
      end
   end

   // ---------------- stimulus ----------------
   function automatic sdsh_pkg::req_type rand_req(input logic [2:0] mode);
      sdsh_pkg::req_type r;
      r.mode = mode;
      r.sector = $urandom;
      r.offset = 9'($urandom_range(0, 511));
      r.count = 10'($urandom_range(1, 512));
      r.write_byte = 8'($urandom_range(0, 255));
      r.card_byte = 8'($urandom_range(0, 255));
      r.discard = 1'($urandom_range(0, 1));
      return r;
   endfunction

   task automatic queue_req(input sdsh_pkg::req_type r);
      sdsh_pkg::rsp_type unused;
      host_step(plan_state, r, unused);
      cmd_queue.push_back(r);
      n_queued++;
   endtask

   // What a well-behaved card returns in the current phase, with some noise.
   function automatic logic [7:0] card_answer(input host_state_type s);
      logic [7:0] r1;
      if ($urandom_range(0, 49) == 0) return 8'($urandom_range(0, 255));
      if (s.ph >= PH_CMD0 && s.ph <= PH_CMD13) begin
         if (s.bcnt < 10'd6 || $urandom_range(0, 2) == 0) return 8'hFF;
         case (s.ph)
            PH_CMD0, PH_CMD58A, PH_CMD55: r1 = 8'h01;
            PH_CMD8: r1 = ($urandom_range(0, 7) == 0) ? 8'h05 : 8'h01;
            PH_ACMD41: r1 = 8'($urandom_range(0, 1));
            PH_CMD24: r1 = ($urandom_range(0, 2) == 0) ? 8'h04 : 8'h00;
            default: r1 = 8'h00;
         endcase
         return r1;
      end
      case (s.ph)
         PH_R7: return (s.bcnt == 10'd2) ? 8'h01 : (s.bcnt == 10'd3) ? 8'hAA : 8'h00;
         PH_OCRA: return (s.bcnt == 10'd1) ? 8'hFF : 8'h80;
         PH_OCRB: return (s.bcnt == 10'd0) ? {1'b1, 1'($urandom_range(0, 1)), 6'd0} : 8'h00;
         PH_TOKEN: return ($urandom_range(0, 2) == 0) ? sdsh_pkg::TOKEN_START : 8'hFF;
         PH_WRESP: return 8'hE5;
         PH_BUSY: return ($urandom_range(0, 2) == 0) ? 8'hFF : 8'h00;
         PH_STAT: return 8'h00;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Answer exchanges until the operation ends; now and then cut it short.
   task automatic serve_card(input bit may_abort);
      sdsh_pkg::req_type r;
      int guard;
      guard = 0;
      while (plan_state.ph != PH_IDLE && guard < 4000) begin
         if (may_abort && $urandom_range(0, 39) == 0) return;
         r = rand_req(sdsh_pkg::MODE_CARD);
         r.card_byte = card_answer(plan_state);
         queue_req(r);
         guard++;
      end
   endtask

   task automatic run_op(input sdsh_pkg::req_type r, input bit may_abort);
      queue_req(r);
      serve_card(may_abort);
   endtask

   task automatic do_write(input logic [31:0] sector, input int nbytes, input bit may_abort);
      sdsh_pkg::req_type r;
      r = rand_req(sdsh_pkg::MODE_OPEN);
      r.sector = sector;
      run_op(r, may_abort);
      repeat (nbytes) run_op(rand_req(sdsh_pkg::MODE_WBYTE), may_abort);
      run_op(rand_req(sdsh_pkg::MODE_FINISH), may_abort);
   endtask

   task automatic wait_drained();
      while (cmd_queue.size() > 0 || rsp_expected.size() > 0 || req_if.valid)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [sdsh_pkg::CSR_IDX_W-1:0] idx,
                            input logic [15:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      case (idx)
         sdsh_pkg::CSR_TOKEN_TIMEOUT: chk_state.token_to = value;
         sdsh_pkg::CSR_BUSY_TIMEOUT: chk_state.busy_to = value;
         sdsh_pkg::CSR_RESPONSE_POLLS: chk_state.polls = value[7:0];
         sdsh_pkg::CSR_INIT_RETRIES: chk_state.retries = value[7:0];
         default: chk_state.wake = value[7:0];
      endcase
      plan_state = chk_state;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      sdsh_pkg::req_type r;
      int pick, target;
      state_reset(chk_state);
      plan_state = chk_state;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: idle card byte, reserved modes, empty writes, init, edge reads
      queue_req(rand_req(sdsh_pkg::MODE_CARD));
      queue_req(rand_req(MODE_RSVD6));
      queue_req(rand_req(MODE_RSVD7));
      run_op(rand_req(sdsh_pkg::MODE_WBYTE), 1'b0);
      run_op(rand_req(sdsh_pkg::MODE_FINISH), 1'b0);
      run_op(rand_req(sdsh_pkg::MODE_INIT), 1'b0);
      r = rand_req(sdsh_pkg::MODE_READ);
      r.sector = 32'hFFFF_FFFF; r.offset = 9'd511; r.count = 10'd512; r.discard = 1'b0;
      run_op(r, 1'b0);
      // full write with a few data bytes and zero padding
      do_write(32'h0000_1234, 6, 1'b0);
      r = rand_req(sdsh_pkg::MODE_WBYTE); r.write_byte = 8'h00;
      run_op(r, 1'b0);
      r.write_byte = 8'hFF;
      run_op(r, 1'b0);
      // empty read window, then abandon it part way with a new init
      r = rand_req(sdsh_pkg::MODE_READ);
      r.sector = 32'd0; r.offset = 9'd0; r.count = 10'd0;
      queue_req(r);
      for (int k = 0; k < 40; k++) begin
         r = rand_req(sdsh_pkg::MODE_CARD);
         r.card_byte = card_answer(plan_state);
         queue_req(r);
      end
      // command while busy: start init, then abandon it
      queue_req(rand_req(sdsh_pkg::MODE_INIT));
      run_op(rand_req(sdsh_pkg::MODE_INIT), 1'b0);

      // random phases, one register setting each
      for (int phase_no = 0; phase_no < 5; phase_no++) begin
         wait_drained();
         case (phase_no)
            0: ;
            1: begin
               write_csr(sdsh_pkg::CSR_TOKEN_TIMEOUT, 16'd1);
               write_csr(sdsh_pkg::CSR_BUSY_TIMEOUT, 16'd1);
               write_csr(sdsh_pkg::CSR_RESPONSE_POLLS, 16'd1);
               write_csr(sdsh_pkg::CSR_INIT_RETRIES, 16'd1);
               write_csr(sdsh_pkg::CSR_WAKEUP_BYTES, 16'd1);
            end
            2: begin
               write_csr(sdsh_pkg::CSR_TOKEN_TIMEOUT, 16'hFFFF);
               write_csr(sdsh_pkg::CSR_BUSY_TIMEOUT, 16'hFFFF);
               write_csr(sdsh_pkg::CSR_RESPONSE_POLLS, 16'd255);
               write_csr(sdsh_pkg::CSR_INIT_RETRIES, 16'd255);
               write_csr(sdsh_pkg::CSR_WAKEUP_BYTES, 16'd255);
            end
            default: begin
               write_csr(sdsh_pkg::CSR_TOKEN_TIMEOUT, 16'($urandom_range(1, 6)));
               write_csr(sdsh_pkg::CSR_BUSY_TIMEOUT, 16'($urandom_range(1, 6)));
               write_csr(sdsh_pkg::CSR_RESPONSE_POLLS, 16'($urandom_range(1, 4)));
               write_csr(sdsh_pkg::CSR_INIT_RETRIES, 16'($urandom_range(1, 4)));
               write_csr(sdsh_pkg::CSR_WAKEUP_BYTES, 16'($urandom_range(1, 20)));
            end
         endcase
         target = n_queued + 25;
         while (n_queued < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) run_op(rand_req(sdsh_pkg::MODE_INIT), 1'b1);
            else if (pick < 45) run_op(rand_req(sdsh_pkg::MODE_READ), 1'b1);
            else if (pick < 65) do_write($urandom, $urandom_range(0, 6), 1'b1);
            else if (pick < 75) run_op(rand_req(sdsh_pkg::MODE_FINISH), 1'b1);
            else if (pick < 85) run_op(rand_req(sdsh_pkg::MODE_WBYTE), 1'b1);
            else queue_req(rand_req(3'($urandom_range(5, 7))));
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (n_errors == 0 && rsp_expected.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Watchdog
   initial begin
      #40_000_000;
      $display("TEST FAILED");
      $finish;
   end
endmodule
`default_nettype wire
